### sv/rk4ds_pkg.sv
// Shared types, constants and helpers for the damped spring RK4 integrator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package rk4ds_pkg;

  // Field and register widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DT_W      = 16;

  // Weighted derivative sums need three bits over a state word.
  localparam int unsigned SUM_W  = DATA_W + 3;

  // Shared multiplier: signed 35 x signed 25.
  localparam int unsigned OPA_W  = SUM_W;
  localparam int unsigned OPB_W  = CFG_W + 1;
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  // Divide-by-three unit: one hex digit per cycle.
  localparam int unsigned DIV_W       = 36;
  localparam int unsigned DIV_DIGIT_W = 4;
  localparam int unsigned DIV_STEPS   = DIV_W / DIV_DIGIT_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Sequencer step counter.
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_LOAD    = 1'b1
  } item_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  // Multiplier operand A source.
  typedef enum logic [2:0] {
    OPA_XS,
    OPA_VS,
    OPA_DV,
    OPA_SX,
    OPA_SV
  } opa_sel_e;

  // Multiplier operand B source.
  typedef enum logic [1:0] {
    OPB_K,
    OPB_B,
    OPB_DT
  } opb_sel_e;

  // What to do with the registered product.
  typedef enum logic [2:0] {
    POST_NONE,
    POST_FX,
    POST_ACC,
    POST_XS,
    POST_VS,
    POST_FSX,
    POST_FSV
  } post_op_e;

  typedef struct packed {
    logic       latch;
    opa_sel_e   opa;
    opb_sel_e   opb;
    post_op_e   post;
    logic       dbl;
    logic       full;
    logic       div_start;
    logic       commit;
    logic       commit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = 64'shFFFF_FFFF_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/rk4ds_if.sv
// Valid/ready channel interfaces for the integrator's input and result words.
// Depends on rk4ds_pkg for the field widths.
`default_nettype none

interface rk4ds_in_if import rk4ds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [DT_W-1:0]          time_step;
  logic signed [DATA_W-1:0] load_position;
  logic signed [DATA_W-1:0] load_velocity;

  modport source (output valid, kind, time_step, load_position, load_velocity,
                  input ready);
  modport sink   (input valid, kind, time_step, load_position, load_velocity,
                  output ready);
endinterface

interface rk4ds_out_if import rk4ds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;

  modport source (output valid, position, velocity, input ready);
  modport sink   (input valid, position, velocity, output ready);
endinterface

`default_nettype wire

### sv/rk4_damped_spring_step.sv
// Top level of the damped spring RK4 integrator: controller plus datapath.
// Needs rk4ds_pkg, rk4ds_if, rk4ds_ctrl, rk4ds_dp (and rk4ds_div3 below it).
//
//   Channel   Dir  Handshake        Word
//   in_i      in   valid / ready    kind, time_step, load_position, load_velocity
//   out_o     out  valid / ready    position, velocity
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (stiffness, damping)
//
// An advance word reaches the result register after acceptance through
// 19 sequencer steps that issue 16 products to the shared 35 x 25 multiplier,
// the divide unit (nine quotient digits, then the done flag) and a commit;
// no new word is taken until the last one has been committed. A load word goes
// from the idle state straight to the commit, which waits for the result register.
// Reset sets the state to zero and the coefficients to 15.0 and 0.1. Input is taken
// whenever the controller is idle, even while a result waits; a finished word waits
// for the result register.
`default_nettype none

module rk4_damped_spring_step import rk4ds_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rk4ds_in_if.sink             in_i,
  rk4ds_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer and handshakes.
  rk4ds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Arithmetic and state.
  rk4ds_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .time_step_i     (in_i.time_step),
    .load_position_i (in_i.load_position),
    .load_velocity_i (in_i.load_velocity),
    .position_o      (out_o.position),
    .velocity_o      (out_o.velocity)
  );

endmodule

`default_nettype wire

### sv/rk4ds_div3.sv
// Two-lane divide-by-three unit, one hex digit of quotient per cycle.
// Used by the datapath for the final division of the weighted sums; needs rk4ds_pkg.
`default_nettype none

module rk4ds_div3 import rk4ds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_x_i,
  input  logic [DIV_W-1:0] num_v_i,
  output logic [DIV_W-1:0] quot_x_o,
  output logic [DIV_W-1:0] quot_v_o,
  output logic             done_o
);

  logic [DIV_W-1:0]     num_q [2];
  logic [DIV_W-1:0]     num_d [2];
  logic [1:0]           rem_q [2];
  logic [1:0]           rem_d [2];
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_CNT_W-1:0] cnt_d;
  logic                 done_q;
  logic                 done_d;

  // Long division of one hex digit by three, a bit at a time.
  // Returns the quotient digit over the new remainder.
  function automatic logic [DIV_DIGIT_W+1:0] div3_digit(input logic [1:0] rem_in,
                                                       input logic [DIV_DIGIT_W-1:0] nib);
    logic [1:0]             r;
    logic [2:0]             t;
    logic [DIV_DIGIT_W-1:0] q;
    r = rem_in;
    q = '0;
    for (int i = DIV_DIGIT_W - 1; i >= 0; i--) begin
      t = {r, nib[i]};
      if (t >= 3'd3) begin
        q[i] = 1'b1;
        r    = 2'(t - 3'd3);
      end else begin
        r    = t[1:0];
      end
    end
    return {q, r};
  endfunction

  // Next digit for each lane; the quotient shifts in where the dividend leaves.
  always_comb begin
    logic [DIV_DIGIT_W+1:0] res;
    for (int l = 0; l < 2; l++) begin
      res      = div3_digit(rem_q[l], num_q[l][DIV_W-1 -: DIV_DIGIT_W]);
      num_d[l] = {num_q[l][DIV_W-DIV_DIGIT_W-1:0], res[DIV_DIGIT_W+1:2]};
      rem_d[l] = res[1:0];
    end
  end

  // Digit counter and completion pulse.
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q[0] <= num_x_i;
      num_q[1] <= num_v_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (cnt_q != '0) begin
      num_q[0] <= num_d[0];
      num_q[1] <= num_d[1];
      rem_q[0] <= rem_d[0];
      rem_q[1] <= rem_d[1];
    end
  end

  assign quot_x_o = num_q[0];
  assign quot_v_o = num_q[1];
  assign done_o   = done_q;

endmodule

`default_nettype wire

### sv/rk4ds_dp.sv
// Datapath of the integrator: state, coefficient registers, shared multiplier,
// post-product arithmetic and the divide-by-three unit. Needs rk4ds_pkg, rk4ds_div3.
`default_nettype none

module rk4ds_dp import rk4ds_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic [DT_W-1:0]          time_step_i,
  input  logic signed [DATA_W-1:0] load_position_i,
  input  logic signed [DATA_W-1:0] load_velocity_i,
  output logic signed [DATA_W-1:0] position_o,
  output logic signed [DATA_W-1:0] velocity_o
);

  // Register reset values: 15.0 clipped to the register, and 0.1 rounded.
  localparam logic [63:0] K_FULL = 64'd15 << FRAC_BITS;
  localparam logic [CFG_W-1:0] K_RESET =
    (K_FULL > 64'h0000_0000_00FF_FFFF) ? {CFG_W{1'b1}} : CFG_W'(K_FULL);
  localparam logic [CFG_W-1:0] B_RESET =
    CFG_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  // Rounding offsets: ties go toward plus infinity.
  localparam logic signed [PROD_W-1:0] HALF_F    = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] HALF_FULL = PROD_W'(64'sd1 <<< (DT_W - 1));
  localparam logic signed [PROD_W-1:0] HALF_HALF = PROD_W'(64'sd1 <<< DT_W);
  localparam logic signed [PROD_W-1:0] HALF_SIX  = PROD_W'(64'sd3 <<< DT_W);
  // Bias that makes the final quotient input positive; a multiple of six.
  localparam logic signed [PROD_W-1:0] DIV_BIAS  = PROD_W'(64'sd6 <<< DATA_W);
  localparam logic signed [63:0]       QUOT_OFF  = 64'sd1 <<< DATA_W;

  logic [CFG_W-1:0]         k_q;
  logic [CFG_W-1:0]         b_q;
  logic signed [DATA_W-1:0] pos_q;
  logic signed [DATA_W-1:0] pos_d;
  logic signed [DATA_W-1:0] vel_q;
  logic signed [DATA_W-1:0] vel_d;

  logic [DT_W-1:0]          dt_q;
  logic signed [DATA_W-1:0] lpos_q;
  logic signed [DATA_W-1:0] lvel_q;
  logic signed [DATA_W-1:0] xs_q;
  logic signed [DATA_W-1:0] xs_d;
  logic signed [DATA_W-1:0] vs_q;
  logic signed [DATA_W-1:0] vs_d;
  logic signed [DATA_W-1:0] dv_q;
  logic signed [DATA_W-1:0] dv_d;
  logic signed [PROD_W-1:0] fx_q;
  logic signed [PROD_W-1:0] fx_d;
  logic signed [SUM_W-1:0]  sx_q;
  logic signed [SUM_W-1:0]  sx_d;
  logic signed [SUM_W-1:0]  sv_q;
  logic signed [SUM_W-1:0]  sv_d;
  logic [DIV_W-1:0]         fsx_q;
  logic [DIV_W-1:0]         fsx_d;
  logic [DIV_W-1:0]         fsv_q;
  logic [DIV_W-1:0]         fsv_d;

  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [PROD_W-1:0] rnd_f;
  logic signed [PROD_W-1:0] rnd_dt;
  logic signed [PROD_W-1:0] q_fin;
  logic signed [PROD_W-1:0] u_fin;
  logic [DIV_W-1:0]         w_fin;
  logic signed [63:0]       acc_sum;
  logic signed [DATA_W-1:0] acc_a;

  logic [DIV_W-1:0]         quot_x;
  logic [DIV_W-1:0]         quot_v;
  logic                     div_done;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd_i.opa)
      OPA_XS:  opa = OPA_W'(xs_q);
      OPA_VS:  opa = OPA_W'(vs_q);
      OPA_DV:  opa = OPA_W'(dv_q);
      OPA_SX:  opa = OPA_W'(sx_q);
      OPA_SV:  opa = OPA_W'(sv_q);
      default: opa = '0;
    endcase
    unique case (cmd_i.opb)
      OPB_K:   opb = $signed({1'b0, k_q});
      OPB_B:   opb = $signed({1'b0, b_q});
      OPB_DT:  opb = $signed(OPB_W'(dt_q));
      default: opb = '0;
    endcase
  end

  assign prod_d = opa * opb;

  // Scaled forms of the registered product.
  always_comb begin
    rnd_f  = (prod_q + HALF_F) >>> FRAC_BITS;
    rnd_dt = cmd_i.full ? ((prod_q + HALF_FULL) >>> DT_W)
                        : ((prod_q + HALF_HALF) >>> (DT_W + 1));
    q_fin  = (prod_q + HALF_SIX) >>> DT_W;
    u_fin  = q_fin + DIV_BIAS;
    // Halve now; the divider then only has to divide by three.
    w_fin  = {1'b0, u_fin[DIV_W-1:1]};
    acc_sum = -64'(fx_q) - 64'(rnd_f);
    acc_a   = sat32(acc_sum);
  end

  // Post-product operations update the evaluation point and the sums.
  always_comb begin
    xs_d  = xs_q;
    vs_d  = vs_q;
    dv_d  = dv_q;
    fx_d  = fx_q;
    sx_d  = sx_q;
    sv_d  = sv_q;
    fsx_d = fsx_q;
    fsv_d = fsv_q;
    if (cmd_i.latch) begin
      xs_d = pos_q;
      vs_d = vel_q;
      sx_d = '0;
      sv_d = '0;
    end else begin
      unique case (cmd_i.post)
        POST_NONE: ;
        POST_FX:   fx_d = rnd_f;
        POST_ACC: begin
          dv_d = acc_a;
          sx_d = sx_q + (cmd_i.dbl ? (SUM_W'(vs_q) <<< 1) : SUM_W'(vs_q));
          sv_d = sv_q + (cmd_i.dbl ? (SUM_W'(acc_a) <<< 1) : SUM_W'(acc_a));
        end
        POST_XS:   xs_d  = sat32(64'(pos_q) + 64'(rnd_dt));
        POST_VS:   vs_d  = sat32(64'(vel_q) + 64'(rnd_dt));
        POST_FSX:  fsx_d = w_fin;
        POST_FSV:  fsv_d = w_fin;
        default: ;
      endcase
    end
  end

  // New state at the end of an item.
  always_comb begin
    logic signed [63:0] psum;
    logic signed [63:0] vsum;
    psum  = 64'(pos_q) + $signed(64'(quot_x)) - QUOT_OFF;
    vsum  = 64'(vel_q) + $signed(64'(quot_v)) - QUOT_OFF;
    pos_d = cmd_i.commit_load ? lpos_q : sat32(psum);
    vel_d = cmd_i.commit_load ? lvel_q : sat32(vsum);
  end

  // Architectural state and coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= K_RESET;
      b_q   <= B_RESET;
      pos_q <= '0;
      vel_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_STIFFNESS: k_q <= cfg_data_i;
          REG_DAMPING:   b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        pos_q <= pos_d;
        vel_q <= vel_d;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      dt_q   <= time_step_i;
      lpos_q <= load_position_i;
      lvel_q <= load_velocity_i;
    end
    prod_q <= prod_d;
    xs_q   <= xs_d;
    vs_q   <= vs_d;
    dv_q   <= dv_d;
    fx_q   <= fx_d;
    sx_q   <= sx_d;
    sv_q   <= sv_d;
    fsx_q  <= fsx_d;
    fsv_q  <= fsv_d;
  end

  rk4ds_div3 u_div3 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_x_i  (fsx_q),
    .num_v_i  (fsv_q),
    .quot_x_o (quot_x),
    .quot_v_o (quot_v),
    .done_o   (div_done)
  );

  assign status_o.div_done = div_done;
  assign position_o        = pos_q;
  assign velocity_o        = vel_q;

endmodule

`default_nettype wire

### sv/rk4ds_ctrl.sv
// Controller of the integrator: handshakes, the step sequencer that drives the
// shared multiplier, and the result word valid flag. Needs rk4ds_pkg.
`default_nettype none

module rk4ds_ctrl import rk4ds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  ctrl_state_e       state_q;
  ctrl_state_e       state_d;
  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  logic              load_q;
  logic              load_d;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              slot_free;

  // The result register can take a new word when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    load_d  = load_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_d  = (item_kind_e'(in_kind_i) == KIND_LOAD);
          step_d  = '0;
          state_d = (item_kind_e'(in_kind_i) == KIND_LOAD) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_DIV;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and the multiplier schedule. A product issued in one step is
  // consumed by the post operation of the next step.
  always_comb begin
    cmd_o             = '0;
    cmd_o.opa         = OPA_XS;
    cmd_o.opb         = OPB_K;
    cmd_o.post        = POST_NONE;
    in_ready_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_RUN: begin
        unique case (step_q)
          // First derivative at the stored state.
          5'd0:  begin cmd_o.opa = OPA_XS; cmd_o.opb = OPB_K;  end
          5'd1:  begin cmd_o.opa = OPA_VS; cmd_o.opb = OPB_B;  cmd_o.post = POST_FX; end
          5'd2:  begin cmd_o.opa = OPA_VS; cmd_o.opb = OPB_DT; cmd_o.post = POST_ACC; end
          // Second derivative, half step along the first.
          5'd3:  begin cmd_o.opa = OPA_DV; cmd_o.opb = OPB_DT; cmd_o.post = POST_XS; end
          5'd4:  begin cmd_o.opa = OPA_XS; cmd_o.opb = OPB_K;  cmd_o.post = POST_VS; end
          5'd5:  begin cmd_o.opa = OPA_VS; cmd_o.opb = OPB_B;  cmd_o.post = POST_FX; end
          5'd6:  begin
            cmd_o.opa = OPA_VS; cmd_o.opb = OPB_DT; cmd_o.post = POST_ACC; cmd_o.dbl = 1'b1;
          end
          // Third derivative, half step along the second.
          5'd7:  begin cmd_o.opa = OPA_DV; cmd_o.opb = OPB_DT; cmd_o.post = POST_XS; end
          5'd8:  begin cmd_o.opa = OPA_XS; cmd_o.opb = OPB_K;  cmd_o.post = POST_VS; end
          5'd9:  begin cmd_o.opa = OPA_VS; cmd_o.opb = OPB_B;  cmd_o.post = POST_FX; end
          5'd10: begin
            cmd_o.opa = OPA_VS; cmd_o.opb = OPB_DT; cmd_o.post = POST_ACC; cmd_o.dbl = 1'b1;
          end
          // Fourth derivative, full step along the third.
          5'd11: begin
            cmd_o.opa = OPA_DV; cmd_o.opb = OPB_DT; cmd_o.post = POST_XS; cmd_o.full = 1'b1;
          end
          5'd12: begin
            cmd_o.opa = OPA_XS; cmd_o.opb = OPB_K; cmd_o.post = POST_VS; cmd_o.full = 1'b1;
          end
          5'd13: begin cmd_o.opa = OPA_VS; cmd_o.opb = OPB_B; cmd_o.post = POST_FX; end
          5'd14: begin cmd_o.post = POST_ACC; end
          // Scale the weighted sums by the time step.
          5'd15: begin cmd_o.opa = OPA_SX; cmd_o.opb = OPB_DT; end
          5'd16: begin cmd_o.opa = OPA_SV; cmd_o.opb = OPB_DT; cmd_o.post = POST_FSX; end
          5'd17: begin cmd_o.post = POST_FSV; end
          5'd18: begin cmd_o.div_start = 1'b1; end
          default: ;
        endcase
      end
      ST_DIV: ;
      ST_FIN: begin
        cmd_o.commit      = slot_free;
        cmd_o.commit_load = load_q;
      end
      default: ;
    endcase
  end

  // Result word valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_FIN && slot_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      load_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      load_q      <= load_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sim/rk4_damped_spring_step_tb.sv
// Testbench for rk4_damped_spring_step: drives load and advance words, tracks the
// expected spring state with a fixed-point RK4 predictor, and checks every result word.
// Depends on rk4ds_pkg, the rk4ds_in_if / rk4ds_out_if interfaces and the integrator RTL.
`timescale 1ns / 100ps

module rk4_damped_spring_step_tb import rk4ds_pkg::*; ();

  localparam int     FRAC          = 16;
  localparam longint ONE_Q16       = 64'sd1 <<< FRAC;
  localparam longint POS_LIMIT     = 64'sd2147483647;
  localparam longint NEG_LIMIT     = -64'sd2147483648;
  localparam int     IDLE_PERCENT  = 21;
  localparam int     DRAIN_CYCLES  = 40;
  localparam int     RX_HOLD_CYCLES = 300;
  localparam int     PHASE_WORDS   = 175;
  localparam int     PHASE_COUNT   = 6;
  localparam logic [CFG_W-1:0] K_RESET = 24'd983040;
  localparam logic [CFG_W-1:0] B_RESET = 24'd6554;
  localparam logic [CFG_W-1:0] CFG_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
  } spring_state_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  rk4ds_in_if  in_if ();
  rk4ds_out_if out_if ();

  rk4_damped_spring_step uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Tracked copy of the block's state and coefficients.
  logic signed [DATA_W-1:0] tracked_pos;
  logic signed [DATA_W-1:0] tracked_vel;
  longint tracked_k;
  longint tracked_b;

  spring_state_t pending_states[$];
  int  fail_count = 0;
  bit  tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic rx_holding = 1'b0;
  event rx_hold_go;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point RK4 predictor.
  // ---------------------------------------------------------------------------

  // Divide with rounding to nearest, ties toward plus infinity.
  function automatic longint div_round(input longint n, input longint d);
    longint t;
    t = n + d / 2;
    if (t >= 0) return t / d;
    return (t - (d - 1)) / d;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > POS_LIMIT) return 32'sh7FFF_FFFF;
    if (v < NEG_LIMIT) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // Spring force per unit mass: -k*x - b*v.
  function automatic logic signed [DATA_W-1:0] spring_accel(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] v
  );
    longint fx;
    longint fv;
    fx = div_round(longint'(x) * tracked_k, ONE_Q16);
    fv = div_round(longint'(v) * tracked_b, ONE_Q16);
    return clamp32(-fx - fv);
  endfunction

  // Slope at the tracked state moved by (dx, dv) * dt / 2^shift.
  function automatic void slope_at(
    input  logic [DT_W-1:0]          dt,
    input  int                       shift,
    input  logic signed [DATA_W-1:0] dx,
    input  logic signed [DATA_W-1:0] dv,
    output logic signed [DATA_W-1:0] odx,
    output logic signed [DATA_W-1:0] odv
  );
    longint den;
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] vs;
    den = 64'sd1 <<< shift;
    xs = clamp32(longint'(tracked_pos) + div_round(longint'(dx) * longint'(dt), den));
    vs = clamp32(longint'(tracked_vel) + div_round(longint'(dv) * longint'(dt), den));
    odx = vs;
    odv = spring_accel(xs, vs);
  endfunction

  // One classic RK4 step of length dt applied to the tracked state.
  function automatic void rk4_advance(input logic [DT_W-1:0] dt);
    logic signed [DATA_W-1:0] adx, adv, bdx, bdv, cdx, cdv, ddx, ddv;
    longint sx;
    longint sv;
    longint den;
    logic signed [DATA_W-1:0] next_pos;
    adx = tracked_vel;
    adv = spring_accel(tracked_pos, tracked_vel);
    slope_at(dt, DT_W + 1, adx, adv, bdx, bdv);
    slope_at(dt, DT_W + 1, bdx, bdv, cdx, cdv);
    slope_at(dt, DT_W, cdx, cdv, ddx, ddv);
    sx = longint'(adx) + 2 * (longint'(bdx) + longint'(cdx)) + longint'(ddx);
    sv = longint'(adv) + 2 * (longint'(bdv) + longint'(cdv)) + longint'(ddv);
    den = 64'sd6 <<< DT_W;
    next_pos = clamp32(longint'(tracked_pos) + div_round(sx * longint'(dt), den));
    tracked_vel = clamp32(longint'(tracked_vel) + div_round(sv * longint'(dt), den));
    tracked_pos = next_pos;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stalls, long hold-off and the field-by-field check.
  // ---------------------------------------------------------------------------

  function automatic void check_result(
    input logic signed [DATA_W-1:0] pos,
    input logic signed [DATA_W-1:0] vel
  );
    spring_state_t want;
    if (pending_states.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result word: expected none, actual pos %0d vel %0d",
               $time, pos, vel);
      return;
    end
    want = pending_states.pop_front();
    if (pos !== want.position) begin
      fail_count++;
      $display("%0t: position mismatch: expected %0d, actual %0d",
               $time, want.position, pos);
    end
    if (vel !== want.velocity) begin
      fail_count++;
      $display("%0t: velocity mismatch: expected %0d, actual %0d",
               $time, want.velocity, vel);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result(out_if.position, out_if.velocity);
      end
      if (rx_holding) begin
        out_if.ready <= 1'b0;
      end else if (rx_gaps_on) begin
        out_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // The receiver's long hold-off, counted here in clock cycles.
  always begin
    @(rx_hold_go);
    rx_holding <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_holding <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks.
  // ---------------------------------------------------------------------------

  // Offer one word and wait for it to be taken; valid stays high after the
  // handshake so that a following word can go back to back.
  task automatic send_word(
    input item_kind_e               kind,
    input logic [DT_W-1:0]          dt,
    input logic signed [DATA_W-1:0] load_pos,
    input logic signed [DATA_W-1:0] load_vel
  );
    spring_state_t next_state;
    while (tx_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= kind;
    in_if.time_step     <= dt;
    in_if.load_position <= load_pos;
    in_if.load_velocity <= load_vel;
    do @(posedge clk); while (!in_if.ready);
    if (kind == KIND_LOAD) begin
      tracked_pos = load_pos;
      tracked_vel = load_vel;
    end else begin
      rk4_advance(dt);
    end
    next_state.position = tracked_pos;
    next_state.velocity = tracked_vel;
    pending_states.push_back(next_state);
  endtask

  // Drop valid and wait until every result is back and the block has settled.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Coefficient write; only called while the block is idle. The enable is a one-cycle
  // strobe, and it is low again before the task returns.
  task automatic write_coeff(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_STIFFNESS) begin
      tracked_k = longint'(value);
    end else begin
      tracked_b = longint'(value);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random value pickers.
  // ---------------------------------------------------------------------------

  function automatic logic signed [DATA_W-1:0] pick_state_word();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom();
      // Mostly realistic values within plus or minus 16.0.
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DT_W'($urandom_range(0, 16'hFFFF));
      default: return DT_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_coeff();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_MAX;
      2, 3:    return CFG_W'($urandom_range(0, 32'h00FF_FFFF));
      // Up to 50.0 keeps the motion from saturating at once.
      default: return CFG_W'($urandom_range(0, 32'h0032_0000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // State and coefficients right after reset.
  task automatic test_reset_state();
    send_word(KIND_ADVANCE, '0, $urandom(), $urandom());
    send_word(KIND_ADVANCE, '1, $urandom(), $urandom());
    wait_idle();
  endtask

  // Loads at the range limits, saturating advances, and a zero step.
  task automatic test_load_extremes();
    send_word(KIND_LOAD, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_word(KIND_ADVANCE, '1, '0, '0);
    send_word(KIND_LOAD, '1, 32'sh8000_0000, 32'sh8000_0000);
    send_word(KIND_ADVANCE, '1, '1, '1);
    send_word(KIND_LOAD, DT_W'($urandom_range(0, 16'hFFFF)), 32'sh8000_0000,
              32'sh7FFF_FFFF);
    send_word(KIND_ADVANCE, '1, '0, '0);
    send_word(KIND_ADVANCE, '0, $urandom(), $urandom());
    send_word(KIND_LOAD, '0, '0, '0);
    wait_idle();
  endtask

  // Step sizes from one LSB to the largest step; load fields must be ignored.
  task automatic test_step_sizes();
    send_word(KIND_LOAD, '0, 32'sh0001_0000, 32'sh0000_0000);
    send_word(KIND_ADVANCE, 16'd1, '0, '0);
    send_word(KIND_ADVANCE, 16'd1092, '0, '0);
    send_word(KIND_ADVANCE, 16'h8000, '0, '0);
    send_word(KIND_ADVANCE, '1, '0, '0);
    send_word(KIND_ADVANCE, 16'd2000, $urandom(), $urandom());
    wait_idle();
  endtask

  // Coefficients at both ends of their range.
  task automatic test_coeff_extremes();
    write_coeff(REG_STIFFNESS, '0);
    write_coeff(REG_DAMPING, '0);
    send_word(KIND_LOAD, '0, 32'sh0003_0000, -32'sh0002_0000);
    send_word(KIND_ADVANCE, '1, '0, '0);
    wait_idle();
    write_coeff(REG_STIFFNESS, CFG_MAX);
    write_coeff(REG_DAMPING, CFG_MAX);
    send_word(KIND_LOAD, '0, 32'sh0000_8000, 32'sh0000_4000);
    send_word(KIND_ADVANCE, '1, '0, '0);
    send_word(KIND_ADVANCE, '1, '0, '0);
    send_word(KIND_ADVANCE, 16'd64, '0, '0);
    wait_idle();
    write_coeff(REG_STIFFNESS, K_RESET);
    write_coeff(REG_DAMPING, B_RESET);
  endtask

  // Receiver holds off while words keep coming, then the sender waits for all
  // results before going on.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    -> rx_hold_go;
    send_word(KIND_LOAD, '0, 32'sh0002_0000, 32'sh0000_0000);
    repeat (9) send_word(KIND_ADVANCE, pick_step(), $urandom(), $urandom());
    tx_gaps_on = 1'b1;
    wait_idle();
    repeat (4) send_word(KIND_ADVANCE, pick_step(), $urandom(), $urandom());
    wait_idle();
  endtask

  // Random traffic over several coefficient settings; one phase runs without
  // any idling on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == 0) begin
        write_coeff(REG_STIFFNESS, K_RESET);
        write_coeff(REG_DAMPING, B_RESET);
      end else begin
        write_coeff(REG_STIFFNESS, pick_coeff());
        write_coeff(REG_DAMPING, pick_coeff());
      end
      if (phase == 1) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on <= 1'b0;
      end
      // Loads start fresh trajectories; runs of advances follow them.
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < 15) begin
          send_word(KIND_LOAD, DT_W'($urandom_range(0, 16'hFFFF)),
                    pick_state_word(), pick_state_word());
        end else begin
          send_word(KIND_ADVANCE, pick_step(), $urandom(), $urandom());
        end
      end
      wait_idle();
      if (phase == 1) begin
        tx_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_STIFFNESS;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_ADVANCE;
    in_if.time_step     = '0;
    in_if.load_position = '0;
    in_if.load_velocity = '0;
    tracked_pos         = '0;
    tracked_vel         = '0;
    tracked_k           = longint'(K_RESET);
    tracked_b           = longint'(B_RESET);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_load_extremes();
    test_step_sizes();
    test_coeff_extremes();
    test_backpressure();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
sv/rk4ds_pkg.sv
sv/rk4ds_if.sv
sv/rk4ds_div3.sv
sv/rk4ds_dp.sv
sv/rk4ds_ctrl.sv
sv/rk4_damped_spring_step.sv
sim/rk4_damped_spring_step_tb.sv
